// File: sv/hmac_sha256_engine_top_macros.svh
// Assertion helpers for the port-level checker.
`ifndef HMAC_SHA256_ENGINE_TOP_MACROS_SVH
`define HMAC_SHA256_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define HSE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset.
`define HSE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/hse_pkg.sv
`timescale 1ns / 1ps
package hse_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [15:0] word16_type;
   typedef word_type [7:0] word8_type;

   typedef struct packed {
      logic       kind;
      logic [31:0] data_word;
      logic [2:0] bytes_valid;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        digest_last;
   } rsp_type;

   // Commands from the sequencer to the compression unit
   typedef struct packed {
      logic       init_h;
      logic       load_pad;
      logic       pad_opad;
      logic       wr_en;
      logic [5:0] wr_pos;
      logic [7:0] wr_byte;
      logic       start;
   } core_cmd_type;

   localparam logic [7:0] IPAD_BYTE = 8'h36;
   localparam logic [7:0] OPAD_BYTE = 8'h5c;
   localparam logic [6:0] BLOCK_BYTES = 7'd64;
   localparam word_type IPAD_WORD = {4{IPAD_BYTE}};
   localparam word_type OPAD_WORD = {4{OPAD_BYTE}};

   localparam word8_type HINIT = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic word_type round_const(input logic [5:0] idx);
      word_type k;
      unique case (idx)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type big_sig0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sig1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sig0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic word_type small_sig1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

endpackage

// File: sv/hse_core.sv
`timescale 1ns / 1ps
// SHA-256 compression unit: one round a cycle, schedule kept in a 16-word window.
module hse_core (
   input  logic                    clock,
   input  logic                    reset,
   input  hse_pkg::core_cmd_type   cmd_in,
   input  hse_pkg::word16_type     key_in,
   output hse_pkg::word8_type      hash_out,
   output logic                    done_out
);

   localparam logic [1:0] C_IDLE  = 2'd0;
   localparam logic [1:0] C_ROUND = 2'd1;
   localparam logic [1:0] C_ADD   = 2'd2;

   logic [1:0]          st_ff;
   logic [5:0]          rnd_ff;
   hse_pkg::word16_type w_ff;
   hse_pkg::word8_type  v_ff;
   hse_pkg::word8_type  h_ff;

   hse_pkg::word_type t1, t2, w_new, pad;
   logic [1:0]        lane;

   always_comb begin
      t1 = v_ff[7] + hse_pkg::big_sig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + hse_pkg::round_const(rnd_ff) + w_ff[0];
      t2 = hse_pkg::big_sig0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      w_new = hse_pkg::small_sig1(w_ff[14]) + w_ff[9] + hse_pkg::small_sig0(w_ff[1]) + w_ff[0];
      pad = cmd_in.pad_opad ? hse_pkg::OPAD_WORD : hse_pkg::IPAD_WORD;
      lane = 2'd3 - cmd_in.wr_pos[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= C_IDLE;
         rnd_ff <= 6'd0;
      end else begin
         unique case (st_ff)
            C_IDLE: begin
               if (cmd_in.start) begin
                  st_ff  <= C_ROUND;
                  rnd_ff <= 6'd0;
               end
            end
            C_ROUND: begin
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) st_ff <= C_ADD;
            end
            C_ADD:   st_ff <= C_IDLE;
            default: st_ff <= C_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == C_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= w_new;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end else begin
         if (cmd_in.load_pad) begin
            for (int i = 0; i < 16; i++) w_ff[i] <= key_in[i] ^ pad;
         end else if (cmd_in.wr_en) begin
            w_ff[cmd_in.wr_pos[5:2]][{lane, 3'b000} +: 8] <= cmd_in.wr_byte;
         end
         if (cmd_in.start) v_ff <= h_ff;
      end
      if (st_ff == C_ADD) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end else if (cmd_in.init_h) begin
         h_ff <= hse_pkg::HINIT;
      end
   end

   assign hash_out = h_ff;
   assign done_out = (st_ff == C_ADD);

endmodule

// File: sv/hmac_sha256_engine_top.sv
`timescale 1ns / 1ps
// HMAC-SHA256 engine. Send key words (kind 0) then message words (kind 1), each carrying
// up to four big-endian bytes; the key holds until the next key word after a finished key,
// and a message word arriving mid-key closes the key first. After the message word marked
// last, eight digest words leave on the rsp channel, word 0 first. One item is handled at a
// time and req_ready is low until it is done, digest transfers included. Bytes enter the
// block buffer one at a time; every 64 bytes hashed run the single round unit (start, 64
// rounds, feed-forward). A last message word adds padding (up to 72 bytes), one or two
// inner blocks, the outer opad block, 32 inner-digest bytes, outer padding and its final
// block before the first digest transfer. A key longer than 64 bytes is hashed as it
// arrives and hashed down to its digest, with its own padding run at its end.
module hmac_sha256_engine_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hse_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hse_pkg::rsp_type rsp_payload
);

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_KBYTES = 4'd1;
   localparam logic [3:0] ST_KFIN   = 4'd2;
   localparam logic [3:0] ST_KSAVE  = 4'd3;
   localparam logic [3:0] ST_IPAD   = 4'd4;
   localparam logic [3:0] ST_MBYTES = 4'd5;
   localparam logic [3:0] ST_FINIT  = 4'd6;
   localparam logic [3:0] ST_FIN    = 4'd7;
   localparam logic [3:0] ST_OPAD   = 4'd8;
   localparam logic [3:0] ST_IBYTES = 4'd9;
   localparam logic [3:0] ST_OUT    = 4'd10;
   localparam logic [3:0] ST_CSTART = 4'd11;
   localparam logic [3:0] ST_CWAIT  = 4'd12;

   // what the engine is in the middle of between items
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_KEY  = 2'd1;
   localparam logic [1:0] PH_MSG  = 2'd2;

   // where a padding run hands over when done
   localparam logic [1:0] FR_KEY   = 2'd0;
   localparam logic [1:0] FR_INNER = 2'd1;
   localparam logic [1:0] FR_OUTER = 2'd2;

   // padding sub-steps
   localparam logic [1:0] FS_MARK = 2'd0;
   localparam logic [1:0] FS_ZERO = 2'd1;
   localparam logic [1:0] FS_LEN  = 2'd2;

   logic [3:0]          state_ff, state_in;
   logic [1:0]          phase_ff, phase_in;
   hse_pkg::req_type    item_ff, item_in;
   logic [2:0]          nb_ff, nb_in;
   logic [2:0]          bidx_ff, bidx_in;
   hse_pkg::word16_type key_ff, key_in;
   logic [6:0]          klen_ff, klen_in;
   logic                hashed_ff, hashed_in;
   logic [63:0]         count_ff, count_in;
   logic [3:0]          cret_ff, cret_in;
   logic [1:0]          fret_ff, fret_in;
   logic [1:0]          fstage_ff, fstage_in;
   logic [3:0]          lidx_ff, lidx_in;
   logic [63:0]         bits_ff, bits_in;
   hse_pkg::word8_type  inner_ff, inner_in;
   logic [5:0]          ibidx_ff, ibidx_in;
   logic [2:0]          oidx_ff, oidx_in;

   hse_pkg::core_cmd_type cmd;
   hse_pkg::word8_type    hash;
   logic                  core_done;

   logic       push_en;
   logic [7:0] push_byte;
   logic [7:0] item_byte;
   logic [1:0] lane;
   logic [1:0] klane;
   logic [1:0] ilane;
   logic [63:0] count_inc;

   hse_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cmd_in   (cmd),
      .key_in   (key_ff),
      .hash_out (hash),
      .done_out (core_done)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_payload.digest_word = hash[oidx_ff];
   assign rsp_payload.word_index  = oidx_ff;
   assign rsp_payload.digest_last = (oidx_ff == 3'd7);

   always_comb begin
      lane      = 2'd3 - bidx_ff[1:0];
      klane     = 2'd3 - klen_ff[1:0];
      ilane     = 2'd3 - ibidx_ff[1:0];
      item_byte = item_ff.data_word[{lane, 3'b000} +: 8];
      count_inc = count_ff + 64'd1;

      state_in  = state_ff;
      phase_in  = phase_ff;
      item_in   = item_ff;
      nb_in     = nb_ff;
      bidx_in   = bidx_ff;
      key_in    = key_ff;
      klen_in   = klen_ff;
      hashed_in = hashed_ff;
      count_in  = count_ff;
      cret_in   = cret_ff;
      fret_in   = fret_ff;
      fstage_in = fstage_ff;
      lidx_in   = lidx_ff;
      bits_in   = bits_ff;
      inner_in  = inner_ff;
      ibidx_in  = ibidx_ff;
      oidx_in   = oidx_ff;
      push_en   = 1'b0;
      push_byte = 8'h00;
      cmd       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_payload;
               nb_in   = (req_payload.bytes_valid > 3'd4) ? 3'd4 : req_payload.bytes_valid;
               bidx_in = 3'd0;
               if (!req_payload.kind) begin
                  if (phase_ff != PH_KEY) begin
                     key_in     = '0;
                     klen_in    = 7'd0;
                     hashed_in  = 1'b0;
                     count_in   = 64'd0;
                     cmd.init_h = 1'b1;
                     phase_in   = PH_KEY;
                  end
                  state_in = ST_KBYTES;
               end else if (phase_ff == PH_KEY) begin
                  state_in = ST_KFIN;
               end else if (phase_ff != PH_MSG) begin
                  state_in = ST_IPAD;
               end else begin
                  state_in = ST_MBYTES;
               end
            end
         end
         ST_KBYTES: begin
            if (bidx_ff < nb_ff) begin
               if (klen_ff < hse_pkg::BLOCK_BYTES) begin
                  key_in[klen_ff[5:2]][{klane, 3'b000} +: 8] = item_byte;
                  klen_in = klen_ff + 7'd1;
               end else begin
                  hashed_in = 1'b1;
               end
               push_en   = 1'b1;
               push_byte = item_byte;
               bidx_in   = bidx_ff + 3'd1;
            end else begin
               state_in = item_ff.last ? ST_KFIN : ST_IDLE;
            end
         end
         ST_KFIN: begin
            if (hashed_ff) begin
               fret_in  = FR_KEY;
               state_in = ST_FINIT;
            end else begin
               phase_in = PH_IDLE;
               state_in = item_ff.kind ? ST_IPAD : ST_IDLE;
            end
         end
         ST_KSAVE: begin
            // long key replaced by its digest, zero-padded
            key_in = '0;
            for (int i = 0; i < 8; i++) key_in[i] = hash[i];
            klen_in  = 7'd32;
            phase_in = PH_IDLE;
            state_in = item_ff.kind ? ST_IPAD : ST_IDLE;
         end
         ST_IPAD: begin
            cmd.init_h   = 1'b1;
            cmd.load_pad = 1'b1;
            count_in     = 64'd64;
            phase_in     = PH_MSG;
            cret_in      = ST_MBYTES;
            state_in     = ST_CSTART;
         end
         ST_MBYTES: begin
            if (bidx_ff < nb_ff) begin
               push_en   = 1'b1;
               push_byte = item_byte;
               bidx_in   = bidx_ff + 3'd1;
            end else if (item_ff.last) begin
               fret_in  = FR_INNER;
               state_in = ST_FINIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FINIT: begin
            bits_in   = {count_ff[60:0], 3'b000};
            fstage_in = FS_MARK;
            lidx_in   = 4'd0;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            unique case (fstage_ff)
               FS_MARK: begin
                  push_en   = 1'b1;
                  push_byte = 8'h80;
                  fstage_in = FS_ZERO;
               end
               FS_ZERO: begin
                  if (count_ff[5:0] == 6'd56) fstage_in = FS_LEN;
                  else push_en = 1'b1;
               end
               FS_LEN: begin
                  if (lidx_ff < 4'd8) begin
                     push_en   = 1'b1;
                     push_byte = bits_ff[{3'd7 - lidx_ff[2:0], 3'b000} +: 8];
                     lidx_in   = lidx_ff + 4'd1;
                  end else begin
                     oidx_in = 3'd0;
                     unique case (fret_ff)
                        FR_KEY:   state_in = ST_KSAVE;
                        FR_INNER: state_in = ST_OPAD;
                        FR_OUTER: state_in = ST_OUT;
                        default:  state_in = ST_IDLE;
                     endcase
                  end
               end
               default: fstage_in = FS_MARK;
            endcase
         end
         ST_OPAD: begin
            inner_in     = hash;
            cmd.init_h   = 1'b1;
            cmd.load_pad = 1'b1;
            cmd.pad_opad = 1'b1;
            count_in     = 64'd64;
            ibidx_in     = 6'd0;
            cret_in      = ST_IBYTES;
            state_in     = ST_CSTART;
         end
         ST_IBYTES: begin
            if (ibidx_ff < 6'd32) begin
               push_en   = 1'b1;
               push_byte = inner_ff[ibidx_ff[4:2]][{ilane, 3'b000} +: 8];
               ibidx_in  = ibidx_ff + 6'd1;
            end else begin
               fret_in  = FR_OUTER;
               state_in = ST_FINIT;
            end
         end
         ST_OUT: begin
            phase_in = PH_IDLE;
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) state_in = ST_IDLE;
            end
         end
         ST_CSTART: begin
            cmd.start = 1'b1;
            state_in  = ST_CWAIT;
         end
         ST_CWAIT: begin
            if (core_done) state_in = cret_ff;
         end
         default: state_in = ST_IDLE;
      endcase

      // byte into the block buffer; a full block goes to the round unit
      if (push_en) begin
         cmd.wr_en   = 1'b1;
         cmd.wr_pos  = count_ff[5:0];
         cmd.wr_byte = push_byte;
         count_in    = count_inc;
         if (count_inc[5:0] == 6'd0) begin
            cret_in  = state_ff;
            state_in = ST_CSTART;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= PH_IDLE;
         key_ff    <= '0;
         klen_ff   <= 7'd0;
         hashed_ff <= 1'b0;
         count_ff  <= 64'd0;
         oidx_ff   <= 3'd0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         key_ff    <= key_in;
         klen_ff   <= klen_in;
         hashed_ff <= hashed_in;
         count_ff  <= count_in;
         oidx_ff   <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      nb_ff     <= nb_in;
      bidx_ff   <= bidx_in;
      cret_ff   <= cret_in;
      fret_ff   <= fret_in;
      fstage_ff <= fstage_in;
      lidx_ff   <= lidx_in;
      bits_ff   <= bits_in;
      inner_ff  <= inner_in;
      ibidx_ff  <= ibidx_in;
   end

endmodule

// File: sv/hse_checker.sv
`timescale 1ns / 1ps
`include "hmac_sha256_engine_top_macros.svh"
// Port-level checks on the engine.
module hse_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input hse_pkg::rsp_type rsp_payload
);

   `HSE_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled digest transfer changed")
   `HSE_ASSERT_IMP(a_busy_out, rsp_valid, !req_ready, "request taken while digest pending")
   `HSE_ASSERT_IMP(a_last_idx, rsp_valid && rsp_payload.digest_last, rsp_payload.word_index == 3'd7, "last flag off the eighth word")
   `HSE_ASSERT_NXT(a_idx_step, rsp_valid && rsp_ready && !rsp_payload.digest_last, rsp_valid && (rsp_payload.word_index == $past(rsp_payload.word_index) + 3'd1), "digest word order broken")

endmodule

bind hmac_sha256_engine_top hse_checker u_hse_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// File: dv/hmac_sha256_checker.sv
`timescale 1ns / 1ps
module hmac_sha256_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  hse_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  hse_pkg::rsp_type rsp_payload,
   output int               fail_count,
   output int               digests_due
);

   typedef enum logic [1:0] {ST_IDLE, ST_KEY, ST_MSG} mac_phase_type;

   localparam hse_pkg::word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };
   localparam hse_pkg::word_type CHAIN_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   hse_pkg::word_type key_words [16];
   logic [6:0]        key_len;
   logic              key_long;
   hse_pkg::word_type chain [8];
   hse_pkg::word_type blk [16];
   logic [63:0]       byte_cnt;
   mac_phase_type     mac_phase;
   hse_pkg::rsp_type  digest_q [$];

   function automatic hse_pkg::word_type ror(hse_pkg::word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void compress_blk();
      hse_pkg::word_type w [64];
      hse_pkg::word_type v [8];
      hse_pkg::word_type t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + w[i-7]
              + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
              + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      v = chain;
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
   endfunction

   function automatic void hash_byte(logic [7:0] b);
      int pos;
      pos = byte_cnt[5:0];
      blk[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = b;
      byte_cnt = byte_cnt + 64'd1;
      if (byte_cnt[5:0] == 6'd0) compress_blk();
   endfunction

   function automatic void hash_open();
      chain = CHAIN_IV;
      byte_cnt = '0;
   endfunction

   function automatic void hash_close(output hse_pkg::word8_type d);
      logic [63:0] bits;
      bits = byte_cnt << 3;
      hash_byte(8'h80);
      while (byte_cnt[5:0] != 6'd56) hash_byte(8'h00);
      for (int i = 0; i < 8; i++) hash_byte(bits[(7 - i) * 8 +: 8]);
      for (int i = 0; i < 8; i++) d[i] = chain[i];
   endfunction

   function automatic void pad_key_blk(hse_pkg::word_type pad);
      hash_open();
      for (int i = 0; i < 16; i++) blk[i] = key_words[i] ^ pad;
      compress_blk();
      byte_cnt = 64'd64;
   endfunction

   function automatic void close_key();
      hse_pkg::word8_type d;
      if (key_long) begin
         hash_close(d);
         for (int i = 0; i < 16; i++) key_words[i] = (i < 8) ? d[i] : '0;
         key_len = 7'd32;
      end
      mac_phase = ST_IDLE;
   endfunction

   function automatic void absorb(hse_pkg::req_type r);
      int nb;
      logic [7:0] b;
      hse_pkg::word8_type inner, mac;
      hse_pkg::rsp_type e;
      nb = (r.bytes_valid > 3'd4) ? 4 : int'(r.bytes_valid);
      if (r.kind == 1'b0) begin
         if (mac_phase != ST_KEY) begin
            foreach (key_words[i]) key_words[i] = '0;
            key_len = '0;
            key_long = 1'b0;
            hash_open();
            mac_phase = ST_KEY;
         end
         for (int i = 0; i < nb; i++) begin
            b = r.data_word[(3 - i) * 8 +: 8];
            if (key_len < hse_pkg::BLOCK_BYTES) begin
               key_words[key_len[5:2]][(3 - key_len[1:0]) * 8 +: 8] = b;
               key_len = key_len + 7'd1;
            end else key_long = 1'b1;
            hash_byte(b);
         end
         if (r.last) close_key();
         return;
      end
      if (mac_phase != ST_MSG) begin
         if (mac_phase == ST_KEY) close_key();
         pad_key_blk(hse_pkg::IPAD_WORD);
         mac_phase = ST_MSG;
      end
      for (int i = 0; i < nb; i++) hash_byte(r.data_word[(3 - i) * 8 +: 8]);
      if (!r.last) return;
      hash_close(inner);
      pad_key_blk(hse_pkg::OPAD_WORD);
      for (int i = 0; i < 32; i++) hash_byte(inner[i >> 2][(3 - (i & 3)) * 8 +: 8]);
      hash_close(mac);
      mac_phase = ST_IDLE;
      for (int i = 0; i < 8; i++) begin
         e.digest_word = mac[i];
         e.word_index  = 3'(i);
         e.digest_last = (i == 7);
         digest_q.insert(digest_q.size(), e);
      end
   endfunction

   always @(posedge clock) begin
      hse_pkg::rsp_type e;
      if (reset) begin
         foreach (key_words[i]) key_words[i] = '0;
         key_len   = '0;
         key_long  = 1'b0;
         byte_cnt  = '0;
         mac_phase = ST_IDLE;
         digest_q.delete();
         fail_count  <= 0;
         digests_due <= 0;
      end else begin
         if (req_valid && req_ready) absorb(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (digest_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected digest transfer: %h idx %0d last %b",
                           rsp_payload.digest_word, rsp_payload.word_index,
                           rsp_payload.digest_last);
               fail_count <= fail_count + 1;
            end else begin
               e = digest_q.pop_front();
               if (e != rsp_payload) begin
                  if (fail_count < 10)
                     $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                              e.digest_word, e.word_index, e.digest_last,
                              rsp_payload.digest_word, rsp_payload.word_index,
                              rsp_payload.digest_last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         digests_due <= digest_q.size();
      end
   end
endmodule

// File: dv/tb_hmac_sha256_engine_top.sv
`timescale 1ns / 1ps
module tb_hmac_sha256_engine_top;

   localparam int WATCHDOG_LIMIT = 20000; // covers the long hold-off plus a full digest
   localparam int HOLD_CYCLES    = 1500;
   localparam int ITEM_TARGET    = 370;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   hse_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   hse_pkg::rsp_type rsp_payload;

   int   fail_count, digests_due;
   int   items_sent = 0;
   int   quiet_cycles = 0;
   int   hold_cnt = 0;
   logic idle_en = 1'b1;
   logic hold_go = 1'b0;
   logic hold_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hmac_sha256_engine_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   hmac_sha256_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .digests_due (digests_due)
   );

   // Receiver: random stalls, plus one long hold-off so the engine backs up
   // and the sender sits on a stalled request.
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_cnt  <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_en && $urandom_range(99) < 28);
      end
   end

   // Watchdog: cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_hmac_sha256_engine_top: FAIL");
         $finish;
      end
   end

   // One request transfer. Valid stays up into the next item unless a gap
   // is taken; gaps are drawn after acceptance so valid gets one update per edge.
   task automatic send_word(logic kind, hse_pkg::word_type data, logic [2:0] nb, logic last);
      hse_pkg::req_type p;
      p.kind = kind;
      p.data_word = data;
      p.bytes_valid = nb;
      p.last = last;
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      while (idle_en && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Mostly full words; now and then a short, empty or oversized byte count.
   function automatic logic [2:0] rand_nb();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 3'd4;
      if (r < 90) return 3'($urandom_range(0, 3));
      return 3'($urandom_range(5, 7));
   endfunction

   task automatic send_key(int words, logic close);
      for (int i = 0; i < words; i++)
         send_word(1'b0, $urandom, rand_nb(), close && (i == words - 1));
   endtask

   task automatic send_msg(int words, logic close);
      for (int i = 0; i < words; i++)
         send_word(1'b1, $urandom, rand_nb(), close && (i == words - 1));
   endtask

   initial begin
      int r, n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty key and empty message straight out of reset
      send_word(1'b1, 32'h0000_0000, 3'd0, 1'b1);
      // oversized byte count on a key, then a one-byte key word closing it
      send_word(1'b0, 32'hffff_ffff, 3'd5, 1'b0);
      send_word(1'b0, 32'ha5a5_a5a5, 3'd1, 1'b1);
      // key kept across messages; invalid byte lanes all ones
      send_word(1'b1, 32'hffff_ffff, 3'd7, 1'b0);
      send_word(1'b1, 32'hffff_ffff, 3'd3, 1'b1);
      send_word(1'b1, 32'h0000_0000, 3'd2, 1'b1);
      // unfinished key closed by a message word
      send_word(1'b0, 32'h1234_5678, 3'd2, 1'b0);
      send_word(1'b1, 32'h8000_0001, 3'd6, 1'b0);
      send_word(1'b1, 32'h0000_0000, 3'd0, 1'b1);
      // new key in the middle of a message throws the message away
      send_word(1'b1, 32'hdead_beef, 3'd4, 1'b0);
      send_word(1'b0, 32'h0000_0000, 3'd4, 1'b0);
      send_word(1'b0, 32'hffff_ffff, 3'd0, 1'b1);
      send_word(1'b1, 32'hcafe_f00d, 3'd4, 1'b1);
      // empty key word with last closes an empty key
      send_word(1'b0, 32'h0000_0000, 3'd0, 1'b1);
      send_word(1'b1, 32'h0102_0304, 3'd4, 1'b1);

      // Random well-formed transactions with some broken ones mixed in
      while (items_sent < ITEM_TARGET) begin
         if (items_sent > 60 && !hold_go) hold_go <= 1'b1;
         idle_en <= !(items_sent >= 180 && items_sent < 260);
         r = $urandom_range(99);
         if (r < 30) begin
            // key, sometimes longer than a block so it gets hashed down
            n = ($urandom_range(9) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 6);
            if (n > 0) send_key(n, 1'b1);
         end else if (r < 36) begin
            send_key($urandom_range(1, 4), 1'b0);
         end
         n = ($urandom_range(5) == 0) ? $urandom_range(14, 34) : $urandom_range(1, 8);
         if ($urandom_range(99) < 90) send_msg(n, 1'b1);
         else send_msg(n, 1'b0);
      end
      req_valid <= 1'b0;

      while (digests_due != 0) @(posedge clock);
      // let a trailing long-key reduction finish
      repeat (600) @(posedge clock);
      if (fail_count == 0 && digests_due == 0)
         $display("tb_hmac_sha256_engine_top: PASS");
      else
         $display("tb_hmac_sha256_engine_top: FAIL");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+sv
sv/hse_pkg.sv
sv/hse_core.sv
sv/hmac_sha256_engine_top.sv
sv/hse_checker.sv
dv/hmac_sha256_checker.sv
dv/tb_hmac_sha256_engine_top.sv
